// ===== rtl/pdc_pkg.sv =====
package pdc_pkg;

    localparam int LOAD_W     = 11;
    localparam int PIPE_W     = 4;
    localparam int RATE_W     = 7;
    localparam int GAIN_W     = 24;
    localparam int ERR_W      = 12;
    localparam int DIF_W      = ERR_W + 1;
    localparam int INT_W      = 32;
    localparam int PROD_P_W   = GAIN_W + ERR_W;
    localparam int PROD_I_W   = GAIN_W + INT_W;
    localparam int PROD_D_W   = GAIN_W + DIF_W;
    localparam int SUM_W      = PROD_I_W + 2;
    localparam int SUM_SHIFT  = 18;
    localparam int QUO_W      = SUM_W - SUM_SHIFT;
    localparam int CNT_W      = 7;
    localparam int ROM_DEPTH  = 100;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [RATE_W-1:0] RATE_MAX = 7'd100;
    localparam logic [CNT_W-1:0]  CNT_LAST = 7'd99;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 8'd3;

    localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = -24'sd6400;

    localparam logic [CNT_W-1:0] PERM_ROM [ROM_DEPTH] = '{
        7'd18, 7'd50, 7'd51, 7'd39, 7'd49, 7'd68, 7'd8,  7'd78, 7'd61, 7'd75,
        7'd53, 7'd32, 7'd45, 7'd77, 7'd31, 7'd12, 7'd26, 7'd10, 7'd37, 7'd99,
        7'd29, 7'd0,  7'd52, 7'd82, 7'd91, 7'd22, 7'd7,  7'd42, 7'd87, 7'd43,
        7'd73, 7'd86, 7'd70, 7'd69, 7'd13, 7'd60, 7'd24, 7'd25, 7'd6,  7'd93,
        7'd96, 7'd97, 7'd84, 7'd47, 7'd79, 7'd64, 7'd90, 7'd81, 7'd4,  7'd15,
        7'd63, 7'd44, 7'd57, 7'd40, 7'd21, 7'd28, 7'd46, 7'd94, 7'd35, 7'd58,
        7'd11, 7'd30, 7'd3,  7'd20, 7'd41, 7'd74, 7'd34, 7'd88, 7'd62, 7'd54,
        7'd33, 7'd92, 7'd76, 7'd85, 7'd5,  7'd72, 7'd9,  7'd83, 7'd56, 7'd17,
        7'd95, 7'd55, 7'd80, 7'd98, 7'd66, 7'd14, 7'd16, 7'd38, 7'd71, 7'd23,
        7'd2,  7'd67, 7'd36, 7'd65, 7'd27, 7'd1,  7'd19, 7'd59, 7'd89, 7'd48
    };

    typedef struct packed {
        logic              func;
        logic              pipe_ok;
        logic [CNT_W-1:0]  rom_val;
    } t_item;

endpackage

// ===== rtl/pdc_if.sv =====
interface pdc_in_if import pdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [LOAD_W-1:0] load_sample;
    logic [PIPE_W-1:0] pipe_index;

    modport source (output valid, func, load_sample, pipe_index, input ready);
    modport sink   (input valid, func, load_sample, pipe_index, output ready);
endinterface

interface pdc_out_if import pdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accept;
    logic [RATE_W-1:0] current_drop_rate;

    modport source (output valid, accept, current_drop_rate, input ready);
    modport sink   (input valid, accept, current_drop_rate, output ready);
endinterface

interface pdc_cfg_if import pdc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pdc_ram.sv =====
module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pid_feedback_drop_controller_top.sv =====
// an accepted request passes through the stage registers and then the output register before its result shows on o_out
// throughput: one item per cycle while the skid stage is empty; the pipe counter read-modify-write
// through the counter ram and the integral update each complete in stage 1
// reset: synchronous, active low; afterwards a clearing pass writes zero to every
// counter ram entry in turn, during which i_in.ready stays low
module pid_feedback_drop_controller_top import pdc_pkg::*; #(
    parameter int PIPE_COUNT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdc_in_if.sink        i_in,
    pdc_out_if.source     o_out,
    pdc_cfg_if.sink       i_cfg
);

    localparam int AW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;

    // configuration
    logic        [LOAD_W-1:0] r_setpoint;
    logic signed [GAIN_W-1:0] r_kp, r_ki, r_kd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_kp       <= '0;
            r_ki       <= GAIN_I_RESET;
            r_kd       <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SETPOINT: r_setpoint <= i_cfg.data[LOAD_W-1:0];
                REG_GAIN_P:   r_kp       <= $signed(i_cfg.data);
                REG_GAIN_I:   r_ki       <= $signed(i_cfg.data);
                REG_GAIN_D:   r_kd       <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    // counter ram clearing pass
    logic          r_clr_done;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (32'(r_clr_addr) == PIPE_COUNT - 1) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // pipeline control
    logic r_skid_v;
    logic w_adv;
    logic w_take;

    assign w_adv      = !r_skid_v;
    assign i_in.ready = w_adv && r_clr_done;
    assign w_take     = i_in.valid && i_in.ready;

    // stage 1
    logic              r_s1_v;
    logic              r_s1_func;
    logic [LOAD_W-1:0] r_s1_load;
    logic [PIPE_W-1:0] r_s1_pipe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_func <= i_in.func;
            r_s1_load <= i_in.load_sample;
            r_s1_pipe <= i_in.pipe_index;
        end
    end

    // counter read-modify-write
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [CNT_W-1:0] w_ram_wdata;
    logic [CNT_W-1:0] w_ram_rdata;
    logic [AW-1:0]    w_s1_addr;
    logic             w_pipe_ok;
    logic             w_cnt_we;
    logic [CNT_W-1:0] w_cnt_old;
    logic [CNT_W-1:0] w_cnt_new;
    logic             r_fwd_v;
    logic [AW-1:0]    r_fwd_addr;
    logic [CNT_W-1:0] r_fwd_data;

    assign w_s1_addr = AW'(r_s1_pipe);
    assign w_pipe_ok = 32'(r_s1_pipe) < PIPE_COUNT;
    assign w_cnt_we  = r_s1_v && (r_s1_func == FUNC_REQUEST) && w_pipe_ok && w_adv;

    // the ram returns old data when written at the same edge it was read
    assign w_cnt_old = (r_fwd_v && (r_fwd_addr == w_s1_addr)) ? r_fwd_data : w_ram_rdata;
    assign w_cnt_new = (w_cnt_old == CNT_LAST) ? '0 : w_cnt_old + 1'b1;

    assign w_ram_we    = !r_clr_done || w_cnt_we;
    assign w_ram_waddr = r_clr_done ? w_s1_addr : r_clr_addr;
    assign w_ram_wdata = r_clr_done ? w_cnt_new : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (w_adv) begin
            r_fwd_v <= w_cnt_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fwd_addr <= w_s1_addr;
            r_fwd_data <= w_cnt_new;
        end
    end

    pdc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (PIPE_COUNT)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_in.ready),
        .i_raddr (AW'(i_in.pipe_index)),
        .o_rdata (w_ram_rdata)
    );

    // pid state update
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [INT_W-1:0] r_integ;
    logic signed [ERR_W-1:0] w_err;
    logic signed [DIF_W-1:0] w_dif;
    logic signed [INT_W:0]   w_int_sum;
    logic signed [INT_W-1:0] w_int_sat;
    logic signed [INT_W-1:0] w_int_new;
    logic                    w_sample_s1;

    assign w_err     = $signed({1'b0, r_setpoint}) - $signed({1'b0, r_s1_load});
    assign w_dif     = $signed({w_err[ERR_W-1], w_err})
                     - $signed({r_prev_err[ERR_W-1], r_prev_err});
    assign w_int_sum = $signed({r_integ[INT_W-1], r_integ})
                     + $signed({{(INT_W + 1 - ERR_W){w_err[ERR_W-1]}}, w_err});

    always_comb begin
        if (w_int_sum[INT_W] != w_int_sum[INT_W-1]) begin
            w_int_sat = w_int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                         : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            w_int_sat = w_int_sum[INT_W-1:0];
        end
    end

    // integral only moves while it or the error is negative
    assign w_int_new   = (r_integ[INT_W-1] || w_err[ERR_W-1]) ? w_int_sat : r_integ;
    assign w_sample_s1 = r_s1_v && (r_s1_func == FUNC_SAMPLE) && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
        end else if (w_sample_s1) begin
            r_prev_err <= w_err;
            r_integ    <= w_int_new;
        end
    end

    // stage 2
    logic                    r_s2_v;
    t_item                   r_s2_item;
    logic signed [ERR_W-1:0] r_s2_err;
    logic signed [DIF_W-1:0] r_s2_dif;
    logic signed [INT_W-1:0] r_s2_int;

    // stage 3
    logic                       r_s3_v;
    t_item                      r_s3_item;
    logic signed [PROD_P_W-1:0] r_s3_pp;
    logic signed [PROD_I_W-1:0] r_s3_pi;
    logic signed [PROD_D_W-1:0] r_s3_pd;

    // stage 4
    logic                    r_s4_v;
    t_item                   r_s4_item;
    logic signed [SUM_W-1:0] r_s4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_item.func    <= r_s1_func;
            r_s2_item.pipe_ok <= w_pipe_ok;
            r_s2_item.rom_val <= PERM_ROM[w_cnt_new];
            r_s2_err          <= w_err;
            r_s2_dif          <= w_dif;
            r_s2_int          <= w_int_new;

            r_s3_item <= r_s2_item;
            r_s3_pp   <= r_kp * r_s2_err;
            r_s3_pi   <= r_ki * r_s2_int;
            r_s3_pd   <= r_kd * r_s2_dif;

            r_s4_item <= r_s3_item;
            r_s4_sum  <= SUM_W'(r_s3_pp) + SUM_W'(r_s3_pi) + SUM_W'(r_s3_pd);
        end
    end

    // stage 4: drop rate and admission decision
    logic [RATE_W-1:0] r_drop;
    logic [RATE_W-1:0] w_rate;
    logic              w_sum_pos;
    logic              w_deliver;
    logic              w_res_accept;
    logic [RATE_W-1:0] w_res_rate;

    assign w_sum_pos = !r_s4_sum[SUM_W-1] && (r_s4_sum != '0);

    always_comb begin
        if (!w_sum_pos) begin
            w_rate = '0;
        end else if (r_s4_sum[SUM_W-1:SUM_SHIFT] > QUO_W'(RATE_MAX)) begin
            w_rate = RATE_MAX;
        end else begin
            w_rate = r_s4_sum[SUM_SHIFT +: RATE_W];
        end
    end

    assign w_deliver = r_s4_v && w_adv;

    always_comb begin
        if (r_s4_item.func == FUNC_SAMPLE) begin
            w_res_accept = 1'b1;
            w_res_rate   = w_rate;
        end else begin
            w_res_accept = r_s4_item.pipe_ok && !(r_s4_item.rom_val < r_drop);
            w_res_rate   = r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= '0;
        end else if (w_deliver && (r_s4_item.func == FUNC_SAMPLE)) begin
            r_drop <= w_rate;
        end
    end

    // output register with skid stage
    logic              r_out_v;
    logic              r_out_accept;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_skid_accept;
    logic [RATE_W-1:0] r_skid_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_deliver) begin
            if (r_out_v && !o_out.ready) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_out.ready) begin
                r_out_accept <= r_skid_accept;
                r_out_rate   <= r_skid_rate;
            end
        end else if (w_deliver) begin
            if (r_out_v && !o_out.ready) begin
                r_skid_accept <= w_res_accept;
                r_skid_rate   <= w_res_rate;
            end else begin
                r_out_accept <= w_res_accept;
                r_out_rate   <= w_res_rate;
            end
        end
    end

    assign o_out.valid             = r_out_v;
    assign o_out.accept            = r_out_accept;
    assign o_out.current_drop_rate = r_out_rate;

endmodule

// ===== rtl/pdc_checker.sv =====
module pdc_checker import pdc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    pdc_in_if.sink    i_in,
    pdc_out_if.source o_out
);

    // the counter clearing pass keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in.ready)
        else $error("input ready right after reset");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.current_drop_rate <= RATE_MAX))
        else $error("drop rate above limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=>
            $stable(o_out.accept) && $stable(o_out.current_drop_rate))
        else $error("result changed while stalled");

endmodule

bind pid_feedback_drop_controller_top pdc_checker u_pdc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pdc_pkg::*;

    localparam int PIPES        = 16;
    localparam int RATE_CEIL    = 100;
    localparam int GAIN_SHIFT   = 18;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 8'd255;

    localparam logic [CFG_DATA_W-1:0] GAIN_MOST  = {1'b0, {(CFG_DATA_W-1){1'b1}}};
    localparam logic [CFG_DATA_W-1:0] GAIN_LEAST = {1'b1, {(CFG_DATA_W-1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0] GAIN_ZERO  = '0;

    // admission order table, read at the advanced pipe position
    localparam logic [CNT_W-1:0] ADMIT_ORDER [100] = '{
        7'd18, 7'd50, 7'd51, 7'd39, 7'd49, 7'd68, 7'd8,  7'd78, 7'd61, 7'd75,
        7'd53, 7'd32, 7'd45, 7'd77, 7'd31, 7'd12, 7'd26, 7'd10, 7'd37, 7'd99,
        7'd29, 7'd0,  7'd52, 7'd82, 7'd91, 7'd22, 7'd7,  7'd42, 7'd87, 7'd43,
        7'd73, 7'd86, 7'd70, 7'd69, 7'd13, 7'd60, 7'd24, 7'd25, 7'd6,  7'd93,
        7'd96, 7'd97, 7'd84, 7'd47, 7'd79, 7'd64, 7'd90, 7'd81, 7'd4,  7'd15,
        7'd63, 7'd44, 7'd57, 7'd40, 7'd21, 7'd28, 7'd46, 7'd94, 7'd35, 7'd58,
        7'd11, 7'd30, 7'd3,  7'd20, 7'd41, 7'd74, 7'd34, 7'd88, 7'd62, 7'd54,
        7'd33, 7'd92, 7'd76, 7'd85, 7'd5,  7'd72, 7'd9,  7'd83, 7'd56, 7'd17,
        7'd95, 7'd55, 7'd80, 7'd98, 7'd66, 7'd14, 7'd16, 7'd38, 7'd71, 7'd23,
        7'd2,  7'd67, 7'd36, 7'd65, 7'd27, 7'd1,  7'd19, 7'd59, 7'd89, 7'd48
    };

    typedef struct packed {
        logic              accept;
        logic [RATE_W-1:0] rate;
    } t_verdict;

    typedef enum {GAINS_MODERATE, GAINS_WIDE, GAINS_EXTREME, GAINS_STEADY} t_gain_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdc_in_if  in_ch();
    pdc_out_if out_ch();
    pdc_cfg_if cfg_ch();

    pid_feedback_drop_controller_top #(
        .PIPE_COUNT (PIPES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // controller copy
    logic [LOAD_W-1:0]        setpoint_q;
    logic signed [GAIN_W-1:0] kp_q;
    logic signed [GAIN_W-1:0] ki_q;
    logic signed [GAIN_W-1:0] kd_q;
    logic signed [ERR_W-1:0]  prev_err_q;
    logic signed [INT_W-1:0]  err_sum;
    logic [RATE_W-1:0]        rate_pct;
    logic [CNT_W-1:0]         pipe_pos [PIPES];

    t_verdict pending_verdicts[$];
    int       mismatches  = 0;
    int       idle_cycles = 0;
    bit       idling_on   = 1'b1;

    function automatic void clear_controller();
        setpoint_q = '0;
        kp_q       = '0;
        ki_q       = GAIN_I_RESET;
        kd_q       = '0;
        prev_err_q = '0;
        err_sum    = '0;
        rate_pct   = '0;
        foreach (pipe_pos[i]) pipe_pos[i] = '0;
    endfunction

    function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SETPOINT: setpoint_q = data[LOAD_W-1:0];
            REG_GAIN_P:   kp_q = data[GAIN_W-1:0];
            REG_GAIN_I:   ki_q = data[GAIN_W-1:0];
            REG_GAIN_D:   kd_q = data[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_verdict admit_or_regulate(logic func, logic [LOAD_W-1:0] load,
                                                   logic [PIPE_W-1:0] pipe);
        t_verdict v;
        longint   err;
        longint   dif;
        longint   acc;
        longint   total;
        int       next_pos;
        v.accept = 1'b1;
        if (func == FUNC_SAMPLE) begin
            err = longint'(setpoint_q) - longint'(load);
            dif = err - longint'(prev_err_q);
            // integral only moves while below zero or on a negative error
            if (err_sum < 0 || err < 0) begin
                acc = longint'(err_sum) + err;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                err_sum = acc[INT_W-1:0];
            end
            total = longint'(kp_q) * err + longint'(ki_q) * longint'(err_sum)
                  + longint'(kd_q) * dif;
            prev_err_q = err[ERR_W-1:0];
            if (total <= 0) begin
                rate_pct = '0;
            end else if ((total >>> GAIN_SHIFT) > RATE_CEIL) begin
                rate_pct = RATE_W'(RATE_CEIL);
            end else begin
                rate_pct = RATE_W'(total >>> GAIN_SHIFT);
            end
        end else if (int'(pipe) >= PIPES) begin
            v.accept = 1'b0;
        end else begin
            next_pos = int'(pipe_pos[pipe]) + 1;
            if (next_pos >= 100) next_pos = 0;
            pipe_pos[pipe] = CNT_W'(next_pos);
            v.accept = (ADMIT_ORDER[pipe_pos[pipe]] < rate_pct) ? 1'b0 : 1'b1;
        end
        v.rate = rate_pct;
        return v;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_result();
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("result with nothing outstanding");
        end else begin
            want = pending_verdicts.pop_front();
            if (out_ch.accept !== want.accept)
                report_mismatch($sformatf("accept %b, expected %b",
                                          out_ch.accept, want.accept));
            if (out_ch.current_drop_rate !== want.rate)
                report_mismatch($sformatf("drop rate %0d, expected %0d",
                                          out_ch.current_drop_rate, want.rate));
        end
    endtask

    // sample all handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (cfg_ch.valid && cfg_ch.ready) load_register(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                pending_verdicts.push_back(admit_or_regulate(in_ch.func, in_ch.load_sample,
                                                             in_ch.pipe_index));
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!idling_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // called and returns at a falling edge
    task automatic send_item(logic func, logic [LOAD_W-1:0] load, logic [PIPE_W-1:0] pipe);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid       <= 1'b0;
            in_ch.func        <= 1'($urandom);
            in_ch.load_sample <= LOAD_W'($urandom);
            in_ch.pipe_index  <= PIPE_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.load_sample <= load;
        in_ch.pipe_index  <= pipe;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_controller(logic [CFG_DATA_W-1:0] sp_word, logic [CFG_DATA_W-1:0] kp,
                                  logic [CFG_DATA_W-1:0] ki, logic [CFG_DATA_W-1:0] kd);
        settle();
        write_register(REG_SETPOINT, sp_word);
        write_register(REG_GAIN_P, kp);
        write_register(REG_GAIN_I, ki);
        write_register(REG_GAIN_D, kd);
    endtask

    // reset gains: zero setpoint, integral gain of minus 6400
    task automatic test_reset_defaults();
        send_item(FUNC_SAMPLE, 11'd1024, 4'd0);
        send_item(FUNC_REQUEST, 11'd0, 4'd0);
        send_item(FUNC_REQUEST, 11'd0, 4'd15);
        send_item(FUNC_SAMPLE, 11'd0, 4'd0);
        send_item(FUNC_SAMPLE, 11'd2047, 4'd0);
    endtask

    // unknown indexes are dropped, setpoint keeps only its low bits
    task automatic test_register_map();
        settle();
        write_register(REG_SPARE_LOW, 24'hFFFFFF);
        write_register(REG_SPARE_HIGH, 24'h000001);
        set_controller(24'hFFFA00, 24'd20000, CFG_DATA_W'(-50), 24'd10000);
        send_item(FUNC_SAMPLE, 11'd300, 4'd0);
        send_item(FUNC_SAMPLE, 11'd700, 4'd0);
        send_item(FUNC_REQUEST, 11'd0, 4'd5);
    endtask

    task automatic test_field_extremes();
        set_controller(24'd2047, GAIN_MOST, GAIN_LEAST, GAIN_LEAST);
        send_item(FUNC_SAMPLE, 11'd0, 4'd15);
        send_item(FUNC_SAMPLE, 11'd2047, 4'd0);
        send_item(FUNC_REQUEST, 11'd2047, 4'd0);
        send_item(FUNC_REQUEST, 11'd0, 4'd15);
        set_controller(24'd0, GAIN_LEAST, GAIN_MOST, GAIN_MOST);
        send_item(FUNC_SAMPLE, 11'd2047, 4'd0);
        send_item(FUNC_SAMPLE, 11'd1024, 4'd0);
    endtask

    // rate pinned at the ceiling drops everything, rate zero admits everything
    task automatic test_rate_limits();
        set_controller(24'd1024, GAIN_MOST, GAIN_ZERO, GAIN_ZERO);
        send_item(FUNC_SAMPLE, 11'd0, 4'd0);
        repeat (3) send_item(FUNC_REQUEST, 11'd0, 4'd3);
        send_item(FUNC_SAMPLE, 11'd1024, 4'd0);
        repeat (2) send_item(FUNC_REQUEST, 11'd0, 4'd3);
        set_controller(24'd1024, GAIN_LEAST, GAIN_ZERO, GAIN_ZERO);
        send_item(FUNC_SAMPLE, 11'd0, 4'd0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_extreme_gain();
        case ($urandom_range(0, 2))
            0:       return GAIN_LEAST;
            1:       return GAIN_MOST;
            default: return GAIN_ZERO;
        endcase
    endfunction

    task automatic random_item();
        logic              func;
        logic [LOAD_W-1:0] load;
        logic [PIPE_W-1:0] pipe;
        int                roll;
        int                near_sp;
        func = ($urandom_range(0, 99) < 40) ? FUNC_SAMPLE : FUNC_REQUEST;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            load = LOAD_W'($urandom_range(0, 1024));
        end else if (roll < 85) begin
            // hover around the setpoint so the error changes sign
            near_sp = int'(setpoint_q) + int'($urandom_range(0, 32)) - 16;
            if (near_sp < 0) near_sp = 0;
            if (near_sp > 2047) near_sp = 2047;
            load = LOAD_W'(near_sp);
        end else begin
            load = LOAD_W'($urandom_range(0, 2047));
        end
        // two busy pipes, 0 and 1, so their positions wrap
        pipe = ($urandom_range(0, 1) == 0) ? PIPE_W'($urandom_range(0, 1))
                                           : PIPE_W'($urandom_range(0, 15));
        send_item(func, load, pipe);
    endtask

    task automatic random_phase(int count, t_gain_mix mix);
        logic [CFG_DATA_W-1:0] sp_word;
        logic [CFG_DATA_W-1:0] kp;
        logic [CFG_DATA_W-1:0] ki;
        logic [CFG_DATA_W-1:0] kd;
        sp_word = CFG_DATA_W'($urandom);
        case (mix)
            GAINS_WIDE: begin
                sp_word[LOAD_W-1:0] = LOAD_W'($urandom_range(0, 1024));
                kp = CFG_DATA_W'($urandom);
                ki = CFG_DATA_W'($urandom);
                kd = CFG_DATA_W'($urandom);
            end
            GAINS_EXTREME: begin
                case ($urandom_range(0, 2))
                    0:       sp_word[LOAD_W-1:0] = 11'd0;
                    1:       sp_word[LOAD_W-1:0] = 11'd1024;
                    default: sp_word[LOAD_W-1:0] = 11'd2047;
                endcase
                kp = pick_extreme_gain();
                ki = pick_extreme_gain();
                kd = pick_extreme_gain();
            end
            default: begin
                sp_word[LOAD_W-1:0] = ($urandom_range(0, 99) < 80)
                                    ? LOAD_W'($urandom_range(0, 1024))
                                    : LOAD_W'($urandom_range(0, 2047));
                kp = CFG_DATA_W'($urandom_range(0, 60000) - 30000);
                ki = CFG_DATA_W'($urandom_range(0, 400) - 200);
                kd = CFG_DATA_W'($urandom_range(0, 60000) - 30000);
            end
        endcase
        set_controller(sp_word, kp, ki, kd);
        idling_on = (mix != GAINS_STEADY);
        repeat (count) random_item();
        idling_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        random_phase(325, GAINS_MODERATE);
        random_phase(325, GAINS_WIDE);
        random_phase(325, GAINS_MODERATE);
        random_phase(325, GAINS_EXTREME);
        random_phase(325, GAINS_STEADY);
        random_phase(325, GAINS_MODERATE);
    endtask

    initial begin
        clear_controller();
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= 1'b0;
        in_ch.load_sample <= '0;
        in_ch.pipe_index  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_map();
        test_field_extremes();
        test_rate_limits();
        test_random_traffic();

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
